@@ rtl/ipsl_pkg.sv @@
// ----------------------------------------------------------------------------
// ipsl_pkg: shared types and constants of the incremental pid speed loop
// gain register layout, register indexes, reset values and datapath widths
// ----------------------------------------------------------------------------
`default_nettype none

package ipsl_pkg;

    // datapath widths
    localparam int unsigned SampleWidth = 16;
    localparam int unsigned GainWidth   = 16;
    localparam int unsigned SepWidth    = 15;
    localparam int unsigned DriveWidth  = 13;
    localparam int unsigned IndexWidth  = 2;
    localparam int unsigned QShift      = 8;

    // reciprocal of ten for a 16-bit magnitude, used as (m * 0xCCCD) >> 19
    localparam logic [15:0] Div10Recip = 16'hCCCD;
    localparam int unsigned Div10Shift = 19;

    // register indexes on the configuration channel
    typedef enum logic [IndexWidth-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2,
        REG_SEP_LIMIT  = 2'd3
    } reg_index_t;

    // reset values of the gain registers (gains are unsigned q8.8)
    localparam logic [GainWidth-1:0] PropGainReset  = 16'd640;
    localparam logic [GainWidth-1:0] IntegGainReset = 16'd10;
    localparam logic [GainWidth-1:0] DerivGainReset = 16'd0;
    localparam logic [SepWidth-1:0]  SepLimitReset  = 15'd500;

    // gain set handed from the register block to the datapath
    typedef struct packed {
        logic [GainWidth-1:0] prop_gain;
        logic [GainWidth-1:0] integ_gain;
        logic [GainWidth-1:0] deriv_gain;
        logic [SepWidth-1:0]  separation_limit;
    } gains_t;

endpackage

`default_nettype wire

@@ rtl/ipsl_gain_regs.sv @@
// ----------------------------------------------------------------------------
// ipsl_gain_regs: gain and separation limit registers
// takes one write word per cycle; writes to unknown indexes are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module ipsl_gain_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [ipsl_pkg::IndexWidth-1:0]   cfg_index,
    input  wire logic [ipsl_pkg::GainWidth-1:0]    cfg_data,
    output      ipsl_pkg::gains_t                  gains
);

    ipsl_pkg::gains_t gains_reg;
    ipsl_pkg::gains_t gains_next;

    // always ready for a write word
    assign cfg_ready = 1'b1;

    // decode the write
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ipsl_pkg::REG_PROP_GAIN:  gains_next.prop_gain  = cfg_data;
                ipsl_pkg::REG_INTEG_GAIN: gains_next.integ_gain = cfg_data;
                ipsl_pkg::REG_DERIV_GAIN: gains_next.deriv_gain = cfg_data;
                ipsl_pkg::REG_SEP_LIMIT:
                    gains_next.separation_limit = cfg_data[ipsl_pkg::SepWidth-1:0];
                default:                  gains_next = gains_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain        <= ipsl_pkg::PropGainReset;
            gains_reg.integ_gain       <= ipsl_pkg::IntegGainReset;
            gains_reg.deriv_gain       <= ipsl_pkg::DerivGainReset;
            gains_reg.separation_limit <= ipsl_pkg::SepLimitReset;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

`default_nettype wire

@@ rtl/incremental_pid_speed_loop_unit.sv @@
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_unit: incremental pid speed loop
// error, three gain products, saturating drive accumulator and divide by ten
// ----------------------------------------------------------------------------
// The unit takes one sample word per cycle unless a stalled drive sink has
// filled every stage, and returns one drive word per sample, in order. A
// sample passes six register stages: input, error and differences, the
// three gain products, the saturating accumulator, the divide-by-ten
// product, and the output register. Each stage has its own valid bit and
// ready, so bubbles close up and samples keep flowing into empty stages
// while a finished drive word waits at the output. The gains and the
// separation limit are written through the configuration channel, which is
// always ready; write them only while no sample is in flight.
`default_nettype none

module incremental_pid_speed_loop_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample words
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] encoder_count, [31:16] speed_target
    // drive words
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,   // [12:0] drive_value, [15:13] zero
    // configuration writes
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ipsl_pkg::gains_t gains;

    // stage valid bits and readies
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic r1, r2, r3, r4, r5, r6;

    // stage 1: sample
    logic signed [15:0] count_reg, target_reg;

    // stage 2: error and differences, history
    logic signed [15:0] err_reg, err_next;
    logic signed [16:0] d1_reg, d1_next;
    logic signed [17:0] d2_reg, d2_next;
    logic               drop_reg, drop_next;
    logic signed [15:0] prev_err_reg, older_err_reg;
    logic signed [16:0] raw_err;

    // stage 3: products
    logic signed [33:0] pterm_reg, pterm_next;
    logic signed [32:0] iterm_reg, iterm_next;
    logic signed [34:0] dterm_reg, dterm_next;
    logic        [15:0] ki_eff;

    // stage 4: accumulator
    logic signed [15:0] acc_reg, acc_next;
    logic signed [35:0] sum36;
    logic signed [35:0] sum_biased;
    logic signed [27:0] inc;
    logic signed [28:0] acc_sum;

    // stage 5: divide-by-ten product
    logic        [31:0] quot_prod_reg, quot_prod_next;
    logic               neg_reg;
    logic        [15:0] acc_mag;

    // stage 6: output
    logic signed [12:0] drive_reg, drive_next;
    logic        [12:0] quot;

    ipsl_gain_regs u_gain_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    // ready chain from the output back to the input
    assign r6 = !v6_reg || m_axis_tready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_axis_tready = r1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= s_axis_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // stage 1: capture the sample word
    always_ff @(posedge clk)
    begin
        if (r1 && s_axis_tvalid)
        begin
            count_reg  <= $signed(s_axis_tdata[15:0]);
            target_reg <= $signed(s_axis_tdata[31:16]);
        end
    end

    // stage 2: saturated error, first and second differences, separation test
    always_comb
    begin
        raw_err = {target_reg[15], target_reg} - {count_reg[15], count_reg};
        if (raw_err[16] != raw_err[15])
            err_next = raw_err[16] ? 16'sh8000 : 16'sh7FFF;
        else
            err_next = raw_err[15:0];
        d1_next = {err_next[15], err_next} - {prev_err_reg[15], prev_err_reg};
        d2_next = {{2{err_next[15]}}, err_next}
                - {prev_err_reg[15], prev_err_reg, 1'b0}
                + {{2{older_err_reg[15]}}, older_err_reg};
        drop_next = $signed({err_next[15], err_next})
                  > $signed({2'b00, gains.separation_limit});
    end

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            err_reg  <= err_next;
            d1_reg   <= d1_next;
            d2_reg   <= d2_next;
            drop_reg <= drop_next;
        end
    end

    // error history, moves once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            older_err_reg <= '0;
        end
        else if (r2 && v1_reg)
        begin
            prev_err_reg  <= err_next;
            older_err_reg <= prev_err_reg;
        end
    end

    // stage 3: the three gain products
    always_comb
    begin
        ki_eff     = drop_reg ? '0 : gains.integ_gain;
        pterm_next = $signed({1'b0, gains.prop_gain}) * d1_reg;
        iterm_next = $signed({1'b0, ki_eff}) * err_reg;
        dterm_next = $signed({1'b0, gains.deriv_gain}) * d2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            pterm_reg <= pterm_next;
            iterm_reg <= iterm_next;
            dterm_reg <= dterm_next;
        end
    end

    // stage 4: increment truncated toward zero, saturating accumulate
    always_comb
    begin
        sum36 = {{2{pterm_reg[33]}}, pterm_reg}
              + {{3{iterm_reg[32]}}, iterm_reg}
              + {dterm_reg[34], dterm_reg};
        sum_biased = sum36 + (sum36[35] ? 36'sd255 : 36'sd0);
        inc = sum_biased[35:ipsl_pkg::QShift];
        acc_sum = {{13{acc_reg[15]}}, acc_reg} + {inc[27], inc};
        if (acc_sum > 29'sd32767)
            acc_next = 16'sh7FFF;
        else if (acc_sum < -29'sd32768)
            acc_next = 16'sh8000;
        else
            acc_next = acc_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (r4 && v3_reg)
            acc_reg <= acc_next;
    end

    // stage 5: magnitude times the reciprocal of ten
    always_comb
    begin
        acc_mag        = acc_reg[15] ? 16'(~acc_reg + 16'sd1) : 16'(acc_reg);
        quot_prod_next = acc_mag * ipsl_pkg::Div10Recip;
    end

    always_ff @(posedge clk)
    begin
        if (r5 && v4_reg)
        begin
            quot_prod_reg <= quot_prod_next;
            neg_reg       <= acc_reg[15];
        end
    end

    // stage 6: restore the sign
    always_comb
    begin
        quot       = quot_prod_reg[ipsl_pkg::Div10Shift +: ipsl_pkg::DriveWidth];
        drive_next = neg_reg ? -$signed(quot) : $signed(quot);
    end

    always_ff @(posedge clk)
    begin
        if (r6 && v5_reg)
            drive_reg <= drive_next;
    end

    assign m_axis_tvalid = v6_reg;
    assign m_axis_tdata  = {3'b000, drive_reg};

endmodule

`default_nettype wire

@@ rtl/ipsl_checker.sv @@
// ----------------------------------------------------------------------------
// ipsl_checker: port-level checks for the incremental pid speed loop
// watches the drive channel and the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module ipsl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // no drive word is offered while in reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("drive word offered during reset");

    // drive word stays within a tenth of the accumulator range, padding clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'b000)
            && ($signed(m_axis_tdata[12:0]) >= -13'sd3276)
            && ($signed(m_axis_tdata[12:0]) <= 13'sd3276))
        else $error("drive word out of range");

    // a stalled drive word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled drive word changed");

    // configuration writes are never back-pressured
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind incremental_pid_speed_loop_unit ipsl_checker u_ipsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

@@ tb/sv/incremental_pid_speed_loop_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// incremental_pid_speed_loop_unit_tb: self-checking bench of the pid speed loop
// sample words go in through a queue-fed driver and drive words are checked
// in order against a bit-exact predictor of the loop, across several gain
// sets, with random gaps and stalls on both streams and one long sink hold-off
// ----------------------------------------------------------------------------

module incremental_pid_speed_loop_unit_tb;

    import ipsl_pkg::*;

    localparam int HalfPeriod    = 6;
    localparam int ResetCycles   = 5;
    localparam int IdlePercent   = 36;
    localparam int HoldAfter     = 330;
    localparam int HoldCycles    = 240;
    localparam int TailCycles    = 24;
    localparam int TimeoutCycles = 100000;
    localparam int QScale        = 1 << QShift;
    localparam int DriveDivisor  = 10;
    localparam logic signed [39:0] DriveMax = 40'sd32767;
    localparam logic signed [39:0] DriveMin = -40'sd32768;

    // one sample word as it sits in s_axis_tdata
    typedef struct packed {
        logic signed [SampleWidth-1:0] speed_target;
        logic signed [SampleWidth-1:0] encoder_count;
    } speed_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] encoder_count, [31:16] speed_target
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [12:0] drive_value, [15:13] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index = REG_PROP_GAIN;
    logic [15:0] cfg_data = '0;

    // gain set and loop state as the predictor sees them
    logic [GainWidth-1:0]         kp_gain   = PropGainReset;
    logic [GainWidth-1:0]         ki_gain   = IntegGainReset;
    logic [GainWidth-1:0]         kd_gain   = DerivGainReset;
    logic [SepWidth-1:0]          sep_limit = SepLimitReset;
    logic signed [SampleWidth-1:0] err_last   = '0;
    logic signed [SampleWidth-1:0] err_before = '0;
    logic signed [SampleWidth-1:0] drive_acc  = '0;

    speed_sample_t          sample_pending[$];
    logic [DriveWidth-1:0]  drive_expected[$];
    int                     samples_taken = 0;
    int                     error_count = 0;
    int                     hold_left = 0;
    logic                   hold_done = 1'b0;
    logic                   stall_hold;
    logic                   calm = 1'b0;

    incremental_pid_speed_loop_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #(HalfPeriod) clk = 1'b1;
        #(HalfPeriod) clk = 1'b0;
    end

    function automatic logic signed [39:0] clamp_i16(logic signed [39:0] v);
        if (v > DriveMax)
            return DriveMax;
        if (v < DriveMin)
            return DriveMin;
        return v;
    endfunction

    // one step of the loop: error, gated increment, saturating accumulate, divide
    function automatic logic [DriveWidth-1:0] predict_drive(speed_sample_t s);
        logic signed [39:0] cnt, tgt, last, older, lim;
        logic signed [39:0] err, d1, d2, kp, ki, kd, sum, acc, quot;
        cnt   = s.encoder_count;
        tgt   = s.speed_target;
        last  = err_last;
        older = err_before;
        lim   = {25'd0, sep_limit};
        kp    = {24'd0, kp_gain};
        kd    = {24'd0, kd_gain};
        err   = clamp_i16(tgt - cnt);
        d1    = err - last;
        d2    = err - 2 * last + older;
        // one-sided separation: only a large positive error drops the integral
        ki    = (err > lim) ? 40'sd0 : {24'd0, ki_gain};
        sum   = kp * d1 + ki * err + kd * d2;
        acc   = clamp_i16(drive_acc + sum / QScale);
        err_before = err_last;
        err_last   = err[SampleWidth-1:0];
        drive_acc  = acc[SampleWidth-1:0];
        quot  = acc / DriveDivisor;
        return quot[DriveWidth-1:0];
    endfunction

    task automatic flag_drive_error(string what, logic [15:0] got, logic [15:0] want);
        $display("drive error (%s): got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sample driver: offers the head of the queue, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            samples_taken <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                drive_expected.push_back(predict_drive(speed_sample_t'(s_axis_tdata)));
                sample_pending.delete(0);
                samples_taken <= samples_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_pending.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IdlePercent))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_pending[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long sink hold-off once the loop is well under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && samples_taken >= HoldAfter)
        begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    assign stall_hold = (hold_left != 0);

    // drive monitor: each accepted word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : drive_monitor
        logic [DriveWidth-1:0] want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_expected.size() == 0)
                    flag_drive_error("unexpected word", m_axis_tdata, '0);
                else
                begin
                    want = drive_expected.pop_front();
                    if (m_axis_tdata !== {3'b000, want})
                        flag_drive_error("value", m_axis_tdata, {3'b000, want});
                end
            end
            m_axis_tready <= !stall_hold && (calm || $urandom_range(0, 99) >= IdlePercent);
        end
    end

    task automatic write_register(reg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  kp_gain   = value;
            REG_INTEG_GAIN: ki_gain   = value;
            REG_DERIV_GAIN: kd_gain   = value;
            REG_SEP_LIMIT:  sep_limit = value[SepWidth-1:0];
            default:        ;
        endcase
    endtask

    task automatic apply_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                               logic [15:0] sep);
        write_register(REG_PROP_GAIN, p);
        write_register(REG_INTEG_GAIN, i);
        write_register(REG_DERIV_GAIN, d);
        write_register(REG_SEP_LIMIT, sep);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_pending.size() != 0 || s_axis_tvalid || drive_expected.size() != 0);
    endtask

    task automatic add_sample(int cnt, int tgt);
        speed_sample_t s;
        s.encoder_count = cnt[15:0];
        s.speed_target  = tgt[15:0];
        sample_pending.push_back(s);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // runs of a held target with the count hovering round it, plus noise
    task automatic queue_phase(int n, int spread);
        int run_left, target, delta, cnt, kind;
        logic [31:0] r;
        run_left = 0;
        target   = 0;
        for (int k = 0; k < n; k++)
        begin
            if (run_left == 0)
            begin
                run_left = int'($urandom_range(4, 30));
                r = $urandom;
                if (r[16])
                    target = int'($signed(r[15:0]));
                else
                    target = int'($urandom_range(0, 6000)) - 3000;
            end
            run_left--;
            kind = int'($urandom_range(0, 99));
            if (kind < 65)
            begin
                delta = int'($urandom_range(0, 2 * spread));
                delta -= spread;
                cnt = target + delta;
                if (cnt > 32767)
                    cnt = 32767;
                if (cnt < -32768)
                    cnt = -32768;
                add_sample(cnt, target);
            end
            else if (kind < 90)
            begin
                r = $urandom;
                add_sample(int'($signed(r[15:0])), int'($signed(r[31:16])));
            end
            else
                add_sample(pick_extreme(), pick_extreme());
        end
    endtask

    // stimulus and phase sequencing
    initial
    begin
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset gains: integral separation edges, negative error, error overflow
        add_sample(0, 0);
        add_sample(0, 100);
        add_sample(0, 600);
        add_sample(0, 500);
        add_sample(0, 501);
        add_sample(1000, -1000);
        add_sample(-32768, 32767);
        add_sample(32767, -32768);
        add_sample(32767, 32767);
        add_sample(-32768, -32768);
        wait_drained();

        // full gains with zero limit: saturation both ways, huge second difference
        apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        add_sample(0, 1);
        add_sample(0, 0);
        add_sample(0, -1);
        add_sample(-32768, 32767);
        add_sample(32767, -32768);
        add_sample(-32768, 32767);
        add_sample(0, -32768);
        add_sample(0, 32767);
        wait_drained();

        apply_gains(PropGainReset, IntegGainReset, DerivGainReset, 16'(SepLimitReset));
        queue_phase(190, 800);
        wait_drained();

        apply_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
                    16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2000)));
        queue_phase(190, 600);
        wait_drained();

        // both streams flat out for a whole phase
        calm = 1'b1;
        apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        queue_phase(180, 300);
        wait_drained();
        calm = 1'b0;

        apply_gains(16'd0, 16'd0, 16'd0, 16'd0);
        queue_phase(160, 400);
        wait_drained();

        apply_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32767)));
        queue_phase(190, 2000);
        wait_drained();

        apply_gains(16'd0, 16'hFFFF, 16'd0, 16'($urandom_range(0, 1000)));
        queue_phase(190, 1200);
        wait_drained();

        apply_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 512)),
                    16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2000)));
        queue_phase(180, 500);
        wait_drained();

        repeat (TailCycles) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TimeoutCycles * 2 * HalfPeriod);
        $display("simulation failed");
        $finish;
    end

endmodule
